[rtl/core/ffds_pkg.sv]
// ----------------------------------------------------------------------------
// ffds_pkg: shared types and constants for the frame deframer scaler
// Frame markers, field widths, register map and the channel cell payload.
// ----------------------------------------------------------------------------
`default_nettype none

package ffds_pkg;

    // default channel count of a frame
    localparam int NUM_CHANNELS_DEF = 16;

    // frame markers
    localparam logic [7:0] HEAD0 = 8'hAA;
    localparam logic [7:0] HEAD1 = 8'hBB;
    localparam logic [7:0] TAIL0 = 8'hCC;
    localparam logic [7:0] TAIL1 = 8'hDD;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int RAW_W    = 16;
    localparam int GAIN_W   = 24;
    localparam int SPLIT_W  = 5;
    localparam int CH_W     = 4;
    localparam int PROD_W   = 40;
    localparam int OUT_TD_W = 48;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_LOW_GAIN  = 2'd0;
    localparam logic [1:0] REG_HIGH_GAIN = 2'd1;
    localparam logic [1:0] REG_SPLIT     = 2'd2;

    localparam logic [GAIN_W-1:0]  LOW_GAIN_RST  = 24'd5120;
    localparam logic [GAIN_W-1:0]  HIGH_GAIN_RST = 24'd16777;
    localparam logic [SPLIT_W-1:0] SPLIT_RST     = 5'd8;

    // one channel held in a channel cell
    typedef struct packed {
        logic signed [RAW_W-1:0] raw;
        logic [CH_W-1:0]         ch;
        logic                    last;
        logic                    use_high;
    } chan_beat_t;

endpackage

`default_nettype wire

[rtl/core/ffds_win_cell.sv]
// ----------------------------------------------------------------------------
// ffds_win_cell: one byte cell of the receive window shift line
// Takes the byte of its younger neighbor on every accepted input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ffds_win_cell
    import ffds_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              shift_en,
    input  wire logic [BYTE_W-1:0] byte_in,
    output logic      [BYTE_W-1:0] byte_out
);

    logic [BYTE_W-1:0] byte_reg;

    // advance the window by one byte
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

[rtl/core/ffds_chan_cell.sv]
// ----------------------------------------------------------------------------
// ffds_chan_cell: one channel cell of the result drain chain
// Loads its channel when a frame is found, then moves toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module ffds_chan_cell
    import ffds_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire logic       shift_en,
    input  wire chan_beat_t load_data,
    input  wire chan_beat_t next_data,
    input  wire logic       next_valid,
    output chan_beat_t      cell_data,
    output logic            cell_valid
);

    chan_beat_t data_reg;
    logic       valid_reg;

    // occupancy: set on load, take the neighbor's on shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (shift_en) begin
            valid_reg <= next_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end else if (shift_en) begin
            data_reg <= next_data;
        end
    end

    assign cell_data  = data_reg;
    assign cell_valid = valid_reg;

endmodule

`default_nettype wire

[rtl/core/ffds_scale.sv]
// ----------------------------------------------------------------------------
// ffds_scale: gain select, multiply and output register
// Scales the head channel by its group gain into the result beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffds_scale
    import ffds_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              head_valid,
    input  wire chan_beat_t        head_data,
    input  wire logic [GAIN_W-1:0] low_gain,
    input  wire logic [GAIN_W-1:0] high_gain,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CH_W-1:0]        out_ch,
    output logic [PROD_W-1:0]      out_value,
    output logic                   out_last
);

    logic                    out_valid_reg;
    logic [CH_W-1:0]         ch_reg;
    logic [PROD_W-1:0]       value_reg;
    logic                    last_reg;
    logic [GAIN_W-1:0]       gain;
    logic signed [GAIN_W:0]  gain_s;
    logic signed [PROD_W:0]  prod;

    // take the head when the output register is free or draining
    assign pop = head_valid && (!out_valid_reg || out_ready);

    // pick the group gain and multiply
    assign gain   = head_data.use_high ? high_gain : low_gain;
    assign gain_s = $signed({1'b0, gain});
    assign prod   = (PROD_W+1)'(head_data.raw) * (PROD_W+1)'(gain_s);

    // output beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            ch_reg    <= head_data.ch;
            value_reg <= prod[PROD_W-1:0];
            last_reg  <= head_data.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ch    = ch_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

[rtl/core/fixed_frame_deframer_scaler.sv]
// ----------------------------------------------------------------------------
// fixed_frame_deframer_scaler: fixed-length frame finder with channel scaling
// Finds AA BB <channels> CC DD frames in a byte stream and emits each
// little-endian int16 channel scaled by a Q0.24 group gain.
// ----------------------------------------------------------------------------
//
//  channel   | direction | tdata (low bit up)             | tlast
//  ----------+-----------+--------------------------------+--------------------
//  s_ bytes  | in        | stream_byte[7:0]               | buffer_end
//  m_ result | out       | channel[3:0], scaled_value[39:0]| frame_last
//  APB cfg   | in        | 0x0 low gain, 0x4 high gain, 0x8 group split
//
//  One input byte per cycle while s_tready is high. A found frame loads all
//  channel cells at once; they drain one result per cycle when m_tready is
//  high, through a single 16x24 multiplier into the output register.
//  The input stalls only when a byte could close a new frame while results
//  of the previous frame still sit in the channel cells.
//  Reset is synchronous; nothing needs a clearing pass.
//
`default_nettype none

module fixed_frame_deframer_scaler
    import ffds_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // byte stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] stream_byte
    input  wire logic                  s_tlast,   // buffer_end
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_TD_W-1:0]        m_tdata,   // [3:0] channel, [43:4] scaled_value
    output logic                       m_tlast,   // frame_last
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int FRAME_LEN = 2 * NUM_CHANNELS + 4;
    localparam int WIN_DEPTH = FRAME_LEN - 1;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

    logic [GAIN_W-1:0]  low_gain_reg;
    logic [GAIN_W-1:0]  high_gain_reg;
    logic [SPLIT_W-1:0] split_reg;

    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [FILL_W-1:0]  skip_reg;
    logic [FILL_W-1:0]  skip_next;

    logic [BYTE_W-1:0]  win [WIN_DEPTH];
    logic               s_fire;
    logic               can_close;
    logic               frame_hit;
    logic               cfg_wr;

    chan_beat_t         cell_data  [NUM_CHANNELS];
    logic               cell_valid [NUM_CHANNELS];
    chan_beat_t         load_data  [NUM_CHANNELS];
    logic               pop;
    logic [CH_W-1:0]    out_ch;
    logic [PROD_W-1:0]  out_value;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_gain_reg  <= LOW_GAIN_RST;
            high_gain_reg <= HIGH_GAIN_RST;
            split_reg     <= SPLIT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LOW_GAIN:  low_gain_reg  <= pwdata[GAIN_W-1:0];
                REG_HIGH_GAIN: high_gain_reg <= pwdata[GAIN_W-1:0];
                REG_SPLIT:     split_reg     <= pwdata[SPLIT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LOW_GAIN:  prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, low_gain_reg};
            REG_HIGH_GAIN: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, high_gain_reg};
            REG_SPLIT:     prdata = {{(APB_DATA_W-SPLIT_W){1'b0}}, split_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- byte window ----------------
    // a byte could close a frame only with a full window outside the skip zone
    assign can_close = (skip_reg == '0) && (fill_reg == FILL_W'(WIN_DEPTH));
    assign s_tready  = !cell_valid[0] || !can_close;
    assign s_fire    = s_tvalid && s_tready;

    assign frame_hit = s_fire && can_close
                    && (win[0] == HEAD0) && (win[1] == HEAD1)
                    && (win[WIN_DEPTH-1] == TAIL0) && (s_tdata == TAIL1);

    // oldest byte at index 0, new bytes enter at the top
    for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_win
        if (i == WIN_DEPTH - 1) begin : g_top
            ffds_win_cell u_cell (
                .aclk     (aclk),
                .shift_en (s_fire),
                .byte_in  (s_tdata),
                .byte_out (win[i])
            );
        end else begin : g_mid
            ffds_win_cell u_cell (
                .aclk     (aclk),
                .shift_en (s_fire),
                .byte_in  (win[i+1]),
                .byte_out (win[i])
            );
        end
    end

    // fill count and skip zone; buffer end drops both
    always_comb begin
        fill_next = fill_reg;
        skip_next = skip_reg;
        if (s_fire) begin
            if (s_tlast) begin
                fill_next = '0;
                skip_next = '0;
            end else begin
                if (fill_reg != FILL_W'(WIN_DEPTH)) begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                if (skip_reg != '0) begin
                    skip_next = skip_reg - FILL_W'(1);
                end else if (frame_hit) begin
                    skip_next = FILL_W'(WIN_DEPTH);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            skip_reg <= '0;
        end else begin
            fill_reg <= fill_next;
            skip_reg <= skip_next;
        end
    end

    // ---------------- channel cells ----------------
    for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_chan
        assign load_data[k].raw      = $signed({win[3+2*k], win[2+2*k]});
        assign load_data[k].ch       = CH_W'(k);
        assign load_data[k].last     = (k == NUM_CHANNELS - 1);
        assign load_data[k].use_high = (8'(k) >= {3'b000, split_reg});

        if (k == NUM_CHANNELS - 1) begin : g_end
            ffds_chan_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .load       (frame_hit),
                .shift_en   (pop),
                .load_data  (load_data[k]),
                .next_data  ('0),
                .next_valid (1'b0),
                .cell_data  (cell_data[k]),
                .cell_valid (cell_valid[k])
            );
        end else begin : g_mid
            ffds_chan_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .load       (frame_hit),
                .shift_en   (pop),
                .load_data  (load_data[k]),
                .next_data  (cell_data[k+1]),
                .next_valid (cell_valid[k+1]),
                .cell_data  (cell_data[k]),
                .cell_valid (cell_valid[k])
            );
        end
    end

    // ---------------- scaling and output ----------------
    ffds_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (cell_valid[0]),
        .head_data  (cell_data[0]),
        .low_gain   (low_gain_reg),
        .high_gain  (high_gain_reg),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_ch     (out_ch),
        .out_value  (out_value),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(OUT_TD_W-CH_W-PROD_W){1'b0}}, out_value, out_ch};

endmodule

`default_nettype wire
